/* rtl/tpdr_pkg.sv */
package tpdr_pkg;

    // field and register widths
    localparam int FUNC_W   = 1;
    localparam int CHUNK_W  = 21;
    localparam int NOW_W    = 48;
    localparam int BYTES_W  = 32;
    localparam int TGT_W    = 16;
    localparam int DELAY_W  = 14;
    localparam int COUNT_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // budget = 1000 * target_seconds stays below 2^26, and pending never exceeds it
    localparam int PEND_W   = 26;
    // serial multiplier: PEND_W multiplier bits times a BYTES_W multiplicand
    localparam int PROD_W   = PEND_W + BYTES_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int USED_W   = NOW_W + 1;
    localparam int DEN_W    = BYTES_W + 1;
    localparam int REM_W    = DEN_W + 1;
    localparam int MUL_STEPS = PEND_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] MIN_CHUNKS   = COUNT_W'(10);
    localparam logic [PEND_W-1:0]  HOLD_MS      = PEND_W'(200);
    localparam logic [PEND_W-1:0]  WHOLE_MS     = PEND_W'(1000);
    localparam logic [PEND_W-1:0]  DROP_MS      = PEND_W'((15 + 1) * 1000);
    localparam logic [DELAY_W-1:0] MAX_DELAY_MS = DELAY_W'(15 * 1000);

    localparam logic [FUNC_W-1:0] FUNC_START = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_CHUNK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXPECTED_BYTES  = 2'd0,
        CFG_TARGET_SECONDS  = 2'd1,
        CFG_REGULATE_ENABLE = 2'd2
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_TS,
        S_BUDGET,
        S_MUL,
        S_DIV,
        S_USED,
        S_EST,
        S_ACC,
        S_ISSUE,
        S_MOD,
        S_DONE
    } t_state;

endpackage

/* rtl/tpdr_in_if.sv */
interface tpdr_in_if
    import tpdr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [CHUNK_W-1:0] chunk_bytes;
    logic [NOW_W-1:0]   now_ms;

    modport source (output valid, output func, output chunk_bytes, output now_ms,
                    input ready);
    modport sink   (input valid, input func, input chunk_bytes, input now_ms,
                    output ready);
endinterface

/* rtl/tpdr_out_if.sv */
interface tpdr_out_if
    import tpdr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DELAY_W-1:0] delay_ms;
    logic               overshoot_flag;

    modport source (output valid, output delay_ms, output overshoot_flag, input ready);
    modport sink   (input valid, input delay_ms, input overshoot_flag, output ready);
endinterface

/* rtl/transfer_pacing_delay_regulator.sv */
// Paces a bulk transfer toward a target duration. A start item (func 0) records now_ms and
// clears the byte count, chunk count, injected and pending delay. Each chunk item (func 1)
// returns one result: the delay to inject now, or the overshoot flag when 16 s or more
// was requested. Items are taken one at a time; the input is ready only while the
// sequencer is idle, and a finished result waits in an output register so the next item
// can be taken before it is drained. A start item goes straight to the output register.
// A chunk before the tenth, with no bytes, or at or past the expected total is issued
// without an estimate; a chunk whose elapsed time already exceeds the budget is issued
// after the budget check; a chunk whose estimate runs over budget or arrives with
// regulation off is issued after one multiply and divide. A fully regulated chunk uses
// the shared bit-serial unit for two 26-step shift-add multiplies and two 58-step
// restoring divides, then peels off k whole seconds (1..15), one per step, when any are
// issued. After a result is loaded the sequencer returns to idle and can take the next item.
module transfer_pacing_delay_regulator
    import tpdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tpdr_in_if.sink               i_in,
    tpdr_out_if.source            o_out
);

    t_state n_state;
    t_state r_state;

    // configuration
    logic [BYTES_W-1:0] r_expected;
    logic [TGT_W-1:0]   r_target;
    logic               r_enable;

    // transfer state
    logic [NOW_W-1:0]   r_start;
    logic [BYTES_W-1:0] r_bytes;
    logic [COUNT_W-1:0] r_count;
    logic [NOW_W-1:0]   r_injected;
    logic [PEND_W-1:0]  r_pending;

    // per-item work registers
    logic [CHUNK_W-1:0] r_chunk;
    logic [NOW_W-1:0]   r_now;
    logic [NOW_W-1:0]   r_ts;
    logic [PEND_W-1:0]  r_budget;
    logic [USED_W-1:0]  r_used;
    logic [DELAY_W-1:0] r_delay;
    logic               r_flag;

    // shared serial multiply / divide
    logic [PROD_W-1:0]  r_num;
    logic [PEND_W-1:0]  r_mplier;
    logic [BYTES_W-1:0] r_mcand;
    logic [DEN_W-1:0]   r_den;
    logic [REM_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_pass;

    // output register
    logic               r_out_valid;
    logic [DELAY_W-1:0] r_out_delay;
    logic               r_out_flag;

    logic               w_in_ready;
    logic               w_out_load;
    logic               w_skip;
    logic               w_over_budget;
    logic [SUM_W-1:0]   w_sum;
    logic               w_sum_over;
    logic [REM_W-1:0]   w_shift;
    logic               w_ge;

    assign w_skip = (r_count < MIN_CHUNKS) || (r_bytes == '0) || (r_expected <= r_bytes);
    assign w_over_budget = r_ts > NOW_W'(r_budget);
    assign w_sum = SUM_W'(r_num) + SUM_W'(r_used);
    assign w_sum_over = w_sum > SUM_W'(r_budget);
    assign w_shift = {r_rem[REM_W-2:0], r_num[PROD_W-1]};
    assign w_ge = w_shift >= REM_W'(r_den);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.func == FUNC_START) ? S_DONE : S_CHECK;
                end
            end
            S_CHECK:  n_state = w_skip ? S_ISSUE : S_TS;
            S_TS:     n_state = S_BUDGET;
            S_BUDGET: n_state = w_over_budget ? S_ISSUE : S_MUL;
            S_MUL:    n_state = (r_cnt == '0) ? S_DIV : S_MUL;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = r_pass ? S_ACC : S_USED;
                end
            end
            S_USED:   n_state = S_EST;
            S_EST:    n_state = (w_sum_over || !r_enable) ? S_ISSUE : S_MUL;
            S_ACC:    n_state = S_ISSUE;
            S_ISSUE: begin
                priority if (r_chunk == '0 || r_pending < HOLD_MS) begin
                    n_state = S_DONE;
                end else if (r_pending < WHOLE_MS || r_pending >= DROP_MS) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MOD;
                end
            end
            S_MOD:    n_state = (r_pending >= WHOLE_MS) ? S_MOD : S_DONE;
            S_DONE:   n_state = w_out_load ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        w_in_ready = (r_state == S_IDLE);
        w_out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);
    end

    assign i_in.ready           = w_in_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.delay_ms       = r_out_delay;
    assign o_out.overshoot_flag = r_out_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_expected  <= '0;
            r_target    <= '0;
            r_enable    <= 1'b1;
            r_start     <= '0;
            r_bytes     <= '0;
            r_count     <= '0;
            r_injected  <= '0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_EXPECTED_BYTES:  r_expected <= i_cfg_data[BYTES_W-1:0];
                    CFG_TARGET_SECONDS:  r_target   <= i_cfg_data[TGT_W-1:0];
                    CFG_REGULATE_ENABLE: r_enable   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // drop valid after the transfer unless a new result loads in the same cycle
            if (r_out_valid && o_out.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_chunk <= i_in.chunk_bytes;
                        r_now   <= i_in.now_ms;
                        r_delay <= '0;
                        r_flag  <= 1'b0;
                        if (i_in.func == FUNC_START) begin
                            r_start    <= i_in.now_ms;
                            r_bytes    <= '0;
                            r_count    <= '0;
                            r_injected <= '0;
                            r_pending  <= '0;
                        end else begin
                            r_bytes <= r_bytes + BYTES_W'(i_in.chunk_bytes);
                            if (r_count < MIN_CHUNKS) begin
                                r_count <= r_count + COUNT_W'(1);
                            end
                        end
                    end
                end
                S_CHECK: begin
                    r_budget <= PEND_W'(r_target) * WHOLE_MS;
                    r_ts     <= (r_now > r_start) ? r_now - r_start : '0;
                    if (w_skip) begin
                        r_pending <= '0;
                    end
                end
                S_TS: begin
                    r_ts <= (r_ts > r_injected) ? r_ts - r_injected : '0;
                end
                S_BUDGET: begin
                    if (w_over_budget) begin
                        r_pending <= '0;
                    end else begin
                        r_num    <= '0;
                        r_mplier <= r_ts[PEND_W-1:0];
                        r_mcand  <= r_expected;
                        r_pass   <= 1'b0;
                        r_cnt    <= CNT_W'(MUL_STEPS - 1);
                    end
                end
                S_MUL: begin
                    // multiplier MSB first: shift the product, add the multiplicand
                    r_num    <= {r_num[PROD_W-2:0], 1'b0}
                              + (r_mplier[PEND_W-1] ? PROD_W'(r_mcand) : '0);
                    r_mplier <= {r_mplier[PEND_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_rem <= '0;
                        r_cnt <= CNT_W'(DIV_STEPS - 1);
                        if (!r_pass) begin
                            r_den <= DEN_W'(r_bytes);
                        end
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_DIV: begin
                    // restoring divide: dividend shifts out on top, quotient in at the bottom
                    r_rem <= w_ge ? w_shift - REM_W'(r_den) : w_shift;
                    r_num <= {r_num[PROD_W-2:0], w_ge};
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                S_USED: begin
                    r_used <= USED_W'(r_injected) + USED_W'(r_pending);
                    r_den  <= DEN_W'(r_expected) - DEN_W'(r_bytes) + DEN_W'(r_chunk);
                end
                S_EST: begin
                    if (w_sum_over || !r_enable) begin
                        r_pending <= '0;
                    end else begin
                        r_mplier <= PEND_W'(SUM_W'(r_budget) - w_sum);
                        r_mcand  <= BYTES_W'(r_chunk);
                        r_num    <= '0;
                        r_pass   <= 1'b1;
                        r_cnt    <= CNT_W'(MUL_STEPS - 1);
                    end
                end
                S_ACC: begin
                    r_pending <= r_pending + r_num[PEND_W-1:0];
                end
                S_ISSUE: begin
                    priority if (r_chunk == '0 || r_pending < HOLD_MS) begin
                        r_delay <= '0;
                    end else if (r_pending < WHOLE_MS) begin
                        r_delay   <= DELAY_W'(r_pending);
                        r_pending <= '0;
                    end else if (r_pending >= DROP_MS) begin
                        r_flag    <= 1'b1;
                        r_pending <= '0;
                    end else begin
                        r_delay <= '0;
                    end
                end
                S_MOD: begin
                    // peel off whole seconds; the remainder stays pending
                    if (r_pending >= WHOLE_MS) begin
                        r_pending <= r_pending - WHOLE_MS;
                        r_delay   <= r_delay + DELAY_W'(WHOLE_MS);
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_delay <= r_delay;
                        r_out_flag  <= r_flag;
                        r_injected  <= r_injected + NOW_W'(r_delay);
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_flag_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overshoot_flag) |-> (o_out.delay_ms == '0))
        else $error("overshoot result carries a delay");

    a_delay_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.delay_ms == '0 ||
                         (o_out.delay_ms >= DELAY_W'(HOLD_MS) &&
                          o_out.delay_ms <= MAX_DELAY_MS)))
        else $error("issued delay out of range");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("accepted transfer not processed");

    a_count_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MIN_CHUNKS)
        else $error("chunk count beyond saturation");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_load) |=> (r_state == S_IDLE && r_out_valid))
        else $error("result not registered on completion");
`endif

endmodule
